FILE: sv/ema_pkg.sv
// shared types and constants of the echo median moving-average unit
// no dependencies; imported by the controller, the datapath and the top level
package ema_pkg;

  // fixed field widths
  localparam int ECHO_W = 15;
  localparam int DIST_W = 17;
  localparam int WIN_W  = 5;

  // conversion constants: 1124 / 256 cm per microsecond in q8, 400 cm limit
  localparam int unsigned SPEED_FACTOR = 1124;
  localparam int unsigned DIST_LIMIT   = 102400;

  // window size after reset, before saturation to the ring depth
  localparam int unsigned RESET_WINDOW = 5;

  // register index of window_size
  localparam int unsigned REG_WINDOW = 0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic conv_en;
    logic med_en;
    logic upd_en;
    logic div_step;
    logic out_load;
  } ema_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic med_bad;
    logic div_done;
  } ema_stat_t;

endpackage

FILE: sv/ema_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ema_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/ema_ctrl.sv
// controller state machine of the echo median moving-average unit
// depends on ema_pkg for the command and status structs
module ema_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ema_pkg::ema_cmd_t   cmd_o,
  input  ema_pkg::ema_stat_t  stat_i
);
  import ema_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MED,
    S_UPD,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   in_beat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_beat     = in_valid_i && !in_stall_o;
  // output register can take a new result when empty or drained this cycle
  assign out_free    = !out_valid_q || !out_stall_i;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == S_IDLE);
    cmd_o.conv_en  = (state_q == S_CONV);
    cmd_o.med_en   = (state_q == S_MED);
    cmd_o.upd_en   = (state_q == S_UPD);
    cmd_o.div_step = (state_q == S_DIV) && !stat_i.div_done;
    cmd_o.out_load = (state_q == S_FIN) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // result register fills on a load and stays full while stalled
      out_valid_q <= cmd_o.out_load || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          state_q <= S_MED;
        end
        S_MED: begin
          state_q <= stat_i.med_bad ? S_FIN : S_UPD;
        end
        S_UPD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (stat_i.div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while a beat waits");

  // an accepted beat starts the conversion step
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_CONV))
    else $error("accepted beat did not start conversion");

  // a result appears only after a load command
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("output valid without load");

endmodule

FILE: sv/ema_dpath.sv
// datapath: echo conversion, median, ring bookkeeping, serial divider, output register
// depends on ema_pkg and ema_ram
module ema_dpath #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ema_pkg::ema_cmd_t             cmd_i,
  output ema_pkg::ema_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [ema_pkg::WIN_W-1:0]     cfg_win_i,
  output logic [ema_pkg::WIN_W-1:0]     win_o,
  input  logic [ema_pkg::ECHO_W-1:0]    echo_time_a_i,
  input  logic [ema_pkg::ECHO_W-1:0]    echo_time_b_i,
  input  logic [ema_pkg::ECHO_W-1:0]    echo_time_c_i,
  output logic [ema_pkg::DIST_W-1:0]    smoothed_distance_o,
  output logic [ema_pkg::DIST_W-1:0]    median_distance_o,
  output logic                          status_o
);
  import ema_pkg::*;

  // ring geometry
  localparam int PW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW      = ((PW > WIN_W) ? PW : WIN_W) + 1;
  localparam int WMAX    = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int WRST    = (RESET_WINDOW < WMAX) ? RESET_WINDOW : WMAX;
  localparam int CNT_W   = $clog2(WMAX + 1);
  localparam int SUM_W   = DIST_W + CNT_W;
  localparam int STW     = $clog2(SUM_W + 1);
  localparam int PROD_W  = ECHO_W + 11;

  // duration to q8 cm; 1124 = 1024 + 64 + 32 + 4, zero when out of range
  function automatic logic [DIST_W-1:0] echo_to_dist(input logic [ECHO_W-1:0] t);
    logic [PROD_W-1:0] te;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-9:0] d;
    te   = PROD_W'(t);
    prod = (te << 10) + (te << 6) + (te << 5) + (te << 2);
    d    = prod[PROD_W-1:8];
    if (d == '0 || d > (PROD_W-8)'(DIST_LIMIT)) begin
      return '0;
    end
    return d[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] mid3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end
    if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  logic [ECHO_W-1:0] ea_q, eb_q, ec_q;
  logic [DIST_W-1:0] da_q, db_q, dc_q;
  logic [DIST_W-1:0] med_d, med_q;
  logic              bad_q;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [MAX_WINDOW-1:0] vld_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [STW-1:0]    step_q;
  logic [DIST_W-1:0] avg_q;
  logic [DIST_W-1:0] avg_d;
  logic [DIST_W-1:0] smooth_q, medo_q;
  logic              stat_q;
  logic [CW-1:0]     pos_x, win_x, pos_eff_x, pos_nxt_x;
  logic [PW-1:0]     pos_eff;
  logic [DIST_W-1:0] ram_rdata, old_val;
  logic              old_full;
  logic [CNT_W:0]    trial;
  logic              trial_ge;

  // input, conversion and median registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ea_q <= echo_time_a_i;
      eb_q <= echo_time_b_i;
      ec_q <= echo_time_c_i;
    end
    if (cmd_i.conv_en) begin
      da_q <= echo_to_dist(ea_q);
      db_q <= echo_to_dist(eb_q);
      dc_q <= echo_to_dist(ec_q);
    end
    if (cmd_i.med_en) begin
      med_q <= med_d;
      bad_q <= (med_d == '0);
    end
  end

  assign med_d          = mid3(da_q, db_q, dc_q);
  assign stat_o.med_bad = (med_d == '0);

  // window saturation on a configuration write
  always_comb begin
    win_d = cfg_win_i;
    if (win_d == '0) begin
      win_d = WIN_W'(1);
    end
    if (win_d > WIN_W'(WMAX)) begin
      win_d = WIN_W'(WMAX);
    end
  end

  assign win_o = win_q;

  // write position wrap
  assign pos_x     = CW'(pos_q);
  assign win_x     = CW'(win_q);
  assign pos_eff_x = (pos_x >= win_x || pos_x >= CW'(MAX_WINDOW)) ? '0 : pos_x;
  assign pos_eff   = pos_eff_x[PW-1:0];
  assign pos_nxt_x = pos_eff_x + CW'(1);
  assign pos_d     = (pos_nxt_x >= win_x) ? '0 : pos_nxt_x[PW-1:0];

  // ring storage, read in the median step and written in the update step
  ema_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd_en),
    .waddr_i (pos_eff),
    .wdata_i (med_q),
    .raddr_i (pos_eff),
    .rdata_o (ram_rdata)
  );

  // an entry without its valid bit reads as empty
  assign old_full = vld_q[pos_eff];
  assign old_val  = old_full ? ram_rdata : '0;
  assign sum_d    = sum_q - SUM_W'(old_val) + SUM_W'(med_q);
  assign cnt_d    = cnt_q - CNT_W'(old_full) + CNT_W'(1);

  // ring bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_W'(WRST);
      pos_q <= '0;
      vld_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      win_q <= win_d;
      pos_q <= '0;
      vld_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd_en) begin
      pos_q          <= pos_d;
      vld_q[pos_eff] <= 1'b1;
      sum_q          <= sum_d;
      cnt_q          <= cnt_d;
    end
  end

  // restoring divider, one quotient bit per step
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.upd_en) begin
      step_q <= STW'(SUM_W);
    end else if (cmd_i.div_step) begin
      step_q <= step_q - STW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      rem_q <= '0;
      quo_q <= sum_d;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
    end
  end

  assign stat_o.div_done = (step_q == '0);

  // last average and output register
  assign avg_d = bad_q ? avg_q : quo_q[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (cmd_i.out_load) begin
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      smooth_q <= avg_d;
      medo_q   <= med_q;
      stat_q   <= bad_q;
    end
  end

  assign smoothed_distance_o = smooth_q;
  assign median_distance_o   = medo_q;
  assign status_o            = stat_q;

  // fill count stays within the window
  a_cnt_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(cnt_q) <= CW'(win_q))
    else $error("filled count exceeds window");

  // write position stays inside the window
  a_pos_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_x < win_x)
    else $error("write position outside window");

  // a finished quotient is a distance in range
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !bad_q) |-> (quo_q <= SUM_W'(DIST_LIMIT)))
    else $error("average out of range");

endmodule

FILE: sv/echo_median_moving_average_unit.sv
// Echo median moving-average unit. Each input beat carries three echo durations
// in microseconds; they become q8 cm distances, the median of the three is stored
// in a ring of window_size entries and the result beat gives the mean of the
// non-empty entries. A new item is accepted only once the last one is through; for
// an item with a valid median the bit-serial divider forms sum / count at one
// quotient bit per cycle. An item whose median is invalid skips the ring update and
// the divider and repeats the last average with status 1. A result beat waits in
// an output register, so the next item may start before it is taken.
// window_size sits at APB address 0; writing it clears the ring.
// depends on ema_pkg, ema_ctrl, ema_dpath and ema_ram
module echo_median_moving_average_unit #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ema_pkg::ECHO_W-1:0]  echo_time_a_i,
  input  logic [ema_pkg::ECHO_W-1:0]  echo_time_b_i,
  input  logic [ema_pkg::ECHO_W-1:0]  echo_time_c_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ema_pkg::DIST_W-1:0]  smoothed_distance_o,
  output logic [ema_pkg::DIST_W-1:0]  median_distance_o,
  output logic                        status_o
);
  import ema_pkg::*;

  ema_cmd_t         cmd;
  ema_stat_t        stat;
  logic             cfg_we;
  logic [WIN_W-1:0] win;

  // apb register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 3'(REG_WINDOW));
  assign prdata = (paddr == 3'(REG_WINDOW)) ? 32'(win) : '0;

  ema_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ema_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we),
    .cfg_win_i           (pwdata[WIN_W-1:0]),
    .win_o               (win),
    .echo_time_a_i       (echo_time_a_i),
    .echo_time_b_i       (echo_time_b_i),
    .echo_time_c_i       (echo_time_c_i),
    .smoothed_distance_o (smoothed_distance_o),
    .median_distance_o   (median_distance_o),
    .status_o            (status_o)
  );

endmodule

FILE: test/echo_median_moving_average_unit_test.sv
// self-checking testbench of the echo median moving-average unit: directed table, then
// random echo triplets over several window settings and pacing modes; depends on ema_pkg and the unit
module echo_median_moving_average_unit_test;
  import ema_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int DIRECTED_ROWS = 20;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 204;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int unsigned REG_UNUSED = 1;
  localparam logic ST_STORED = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [DIST_W-1:0] smoothed;
    logic [DIST_W-1:0] median;
    logic              status;
  } echo_result_t;

  typedef struct packed {
    logic [ECHO_W-1:0] a;
    logic [ECHO_W-1:0] b;
    logic [ECHO_W-1:0] c;
    logic              typed;
    echo_result_t      want;
  } echo_row_t;

  // dut ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ECHO_W-1:0] echo_time_a_i = '0;
  logic [ECHO_W-1:0] echo_time_b_i = '0;
  logic [ECHO_W-1:0] echo_time_c_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DIST_W-1:0] smoothed_distance_o;
  logic [DIST_W-1:0] median_distance_o;
  logic              status_o;

  // filter state as the predictor sees it
  logic [DIST_W-1:0] stored_median [RING_DEPTH];
  logic [3:0]        next_slot;
  logic [20:0]       median_total;
  logic [WIN_W-1:0]  stored_count;
  logic [DIST_W-1:0] mean_hold;
  logic [WIN_W-1:0]  window_len;

  echo_result_t expected_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_checked = 0;
  int unsigned  rejected_seen = 0;
  int unsigned  items_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int           send_calm_left = 0;
  int           recv_calm_left = 0;
  int unsigned  quiet_cycles = 0;

  // window settings walked by the random phases, extremes and out-of-range values included
  logic [31:0] phase_window [PHASES] = '{32'd16, 32'd1, 32'd0, 32'd31, 32'd7, 32'd17,
                                         32'd3, 32'd12};

  // directed beats; expectations typed in only for rejected medians before any average
  echo_row_t directed_rows [DIRECTED_ROWS] = '{
    '{15'd0,     15'd0,     15'd0,     1'b1, '{17'd0, 17'd0, ST_REJECTED}},
    '{15'd32767, 15'd32767, 15'd32767, 1'b1, '{17'd0, 17'd0, ST_REJECTED}},
    '{15'd23323, 15'd0,     15'd32767, 1'b1, '{17'd0, 17'd0, ST_REJECTED}},
    '{15'd1,     15'd1,     15'd1,     1'b0, '0},
    '{15'd23322, 15'd23322, 15'd23322, 1'b0, '0},
    '{15'd0,     15'd1000,  15'd2000,  1'b0, '0},
    '{15'd0,     15'd0,     15'd5000,  1'b0, '0},
    '{15'd32767, 15'd100,   15'd200,   1'b0, '0},
    '{15'd5000,  15'd5000,  15'd0,     1'b0, '0},
    '{15'd30000, 15'd1,     15'd30000, 1'b0, '0},
    '{15'd23323, 15'd23322, 15'd23322, 1'b0, '0},
    '{15'd21845, 15'd10922, 15'd16384, 1'b0, '0},
    '{15'd10922, 15'd21845, 15'd16383, 1'b0, '0},
    '{15'd300,   15'd400,   15'd500,   1'b0, '0},
    '{15'd600,   15'd700,   15'd800,   1'b0, '0},
    '{15'd900,   15'd1000,  15'd1100,  1'b0, '0},
    '{15'd1,     15'd2,     15'd3,     1'b0, '0},
    '{15'd29000, 15'd28000, 15'd27000, 1'b0, '0},
    '{15'd58,    15'd59,    15'd60,    1'b0, '0},
    '{15'd57,    15'd0,     15'd0,     1'b0, '0}
  };

  echo_median_moving_average_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .echo_time_a_i       (echo_time_a_i),
    .echo_time_b_i       (echo_time_b_i),
    .echo_time_c_i       (echo_time_c_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .smoothed_distance_o (smoothed_distance_o),
    .median_distance_o   (median_distance_o),
    .status_o            (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // empty ring, keep the last average
  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) stored_median[i] = '0;
    next_slot = '0;
    median_total = '0;
    stored_count = '0;
  endfunction

  // window register write: zero counts as one, saturate at ring depth
  function automatic void set_window(input logic [31:0] value);
    logic [WIN_W-1:0] w;
    w = value[WIN_W-1:0];
    if (w == 0) w = WIN_W'(1);
    if (w > RING_DEPTH) w = WIN_W'(RING_DEPTH);
    window_len = w;
    clear_ring();
  endfunction

  // echo time to q8 cm; out-of-range distances come back as zero
  function automatic logic [DIST_W-1:0] echo_distance(input logic [ECHO_W-1:0] t);
    logic [31:0] d;
    d = (32'(t) * SPEED_FACTOR) >> 8;
    if (d == 0 || d > DIST_LIMIT) return '0;
    return DIST_W'(d);
  endfunction

  // median of three distances, then ring update and running mean
  function automatic echo_result_t filter_echo(input logic [ECHO_W-1:0] a,
                                               input logic [ECHO_W-1:0] b,
                                               input logic [ECHO_W-1:0] c);
    logic [DIST_W-1:0] da, db, dc, lo, hi, med, old;
    logic [WIN_W-1:0]  slot;
    echo_result_t      res;
    da = echo_distance(a);
    db = echo_distance(b);
    dc = echo_distance(c);
    lo = (da < db) ? da : db;
    hi = (da < db) ? db : da;
    if (dc <= lo) med = lo;
    else if (dc >= hi) med = hi;
    else med = dc;
    if (med == 0) begin
      res.smoothed = mean_hold;
      res.median = '0;
      res.status = ST_REJECTED;
      return res;
    end
    slot = WIN_W'(next_slot);
    if (slot >= window_len) slot = '0;
    old = stored_median[slot];
    if (old != 0) begin
      median_total = median_total - 21'(old);
      stored_count = stored_count - WIN_W'(1);
    end
    stored_median[slot] = med;
    median_total = median_total + 21'(med);
    stored_count = stored_count + WIN_W'(1);
    slot = slot + WIN_W'(1);
    if (slot >= window_len) slot = '0;
    next_slot = slot[3:0];
    mean_hold = DIST_W'(median_total / 21'(stored_count));
    res.smoothed = mean_hold;
    res.median = med;
    res.status = ST_STORED;
    return res;
  endfunction

  // random pause with occasional calm stretches
  function automatic bit take_pause(input int unsigned pct, inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 1'b0;
    end
    if ($urandom_range(99) < 2) begin
      calm_left = $urandom_range(30, 5);
      return 1'b0;
    end
    return ($urandom_range(99) < pct);
  endfunction

  // mostly plausible echo times, some timeouts, far echoes and range edges
  function automatic logic [ECHO_W-1:0] random_echo();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return ECHO_W'($urandom_range(32767, 23323));
    if (r < 20) begin
      case ($urandom_range(3))
        0: return ECHO_W'(1);
        1: return ECHO_W'(23322);
        2: return ECHO_W'(23323);
        default: return '1;
      endcase
    end
    if (r < 30) return ECHO_W'($urandom_range(400, 1));
    return ECHO_W'($urandom_range(23322, 1));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %0d want %0d", results_checked, what, got, want);
    mismatch_count++;
  endtask

  // one beat through the input handshake, expectation queued on acceptance
  task automatic send_echo(input logic [ECHO_W-1:0] a, input logic [ECHO_W-1:0] b,
                           input logic [ECHO_W-1:0] c, input logic typed,
                           input echo_result_t want);
    echo_result_t predicted;
    while (take_pause(send_idle_pct, send_calm_left)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_time_a_i <= a;
    echo_time_b_i <= b;
    echo_time_c_i <= c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = filter_echo(a, b, c);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // configuration write, setup then access
  task automatic write_register(input int unsigned index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(index * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_WINDOW) set_window(value);
  endtask

  // hold the input idle until every pending result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= take_pause(recv_stall_pct, recv_calm_left);
  end

  // result checker
  always @(posedge clk_i) begin
    echo_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(status_o), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (smoothed_distance_o !== want.smoothed)
          report_mismatch("smoothed_distance", 32'(smoothed_distance_o),
                          32'(want.smoothed));
        if (median_distance_o !== want.median)
          report_mismatch("median_distance", 32'(median_distance_o), 32'(want.median));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (status_o === ST_REJECTED) rejected_seen++;
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    pace_e pace;
    clear_ring();
    mean_hold = '0;
    window_len = WIN_W'(RESET_WINDOW);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset window
    foreach (directed_rows[i])
      send_echo(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_register(REG_WINDOW, phase_window[p]);
      // the unused index must leave window and ring untouched
      if (p == 4) write_register(REG_UNUSED, 32'd9);
      pace = pace_e'(p % 4);
      case (pace)
        PACE_FREE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        PACE_SENDER: begin
          send_idle_pct = 77;
          recv_stall_pct = 0;
        end
        PACE_RECEIVER: begin
          send_idle_pct = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_echo(random_echo(), random_echo(), random_echo(), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("sent %0d echo triplets across %0d window settings and four pacing modes",
             items_sent, PHASES + 1);
    $display("checked %0d results, %0d with a rejected median", results_checked,
             rejected_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
